// ===== src/vnorm_pkg.sv =====
// ----------------------------------------------------------------------------
// vnorm_pkg
// Shared types and constants of the vector normalization pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vnorm_pkg;

	// One square-root stage per result bit
	localparam int unsigned SQRT_STAGES = 32;
	// One divider stage per quotient bit (quotient never exceeds 2^30)
	localparam int unsigned DIV_STAGES  = 31;
	localparam int unsigned COMP_W      = 32;
	localparam int unsigned NUM_COMP    = 3;

	// Per-word flags carried down the whole pipeline
	typedef struct packed {
		logic                zero;
		logic [NUM_COMP-1:0] neg;
	} flags_t;

	// Sideband that travels beside the square root
	typedef struct packed {
		flags_t                           flags;
		logic [NUM_COMP-1:0][COMP_W-1:0]  mag_abs;
	} side_t;

endpackage

`default_nettype wire

// ===== src/vnorm_sqrt.sv =====
// ----------------------------------------------------------------------------
// vnorm_sqrt
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vnorm_sqrt (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire logic [63:0]      radicand,
	input  wire vnorm_pkg::side_t in_side,
	output logic                  out_valid,
	output logic [31:0]           root,
	output vnorm_pkg::side_t      out_side
);

	localparam int unsigned N = vnorm_pkg::SQRT_STAGES;

	logic                  v_s    [N];
	logic [63:0]           rad_s  [N];
	logic [32:0]           rem_s  [N];
	logic [31:0]           root_s [N];
	vnorm_pkg::side_t      side_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic             cur_v;
		logic [63:0]      cur_rad;
		logic [32:0]      cur_rem;
		logic [31:0]      cur_root;
		vnorm_pkg::side_t cur_side;
		logic [34:0]      trial;
		logic [34:0]      sub;
		logic             ge;

		if (k == 0) begin : g_first
			assign cur_v    = in_valid;
			assign cur_rad  = radicand;
			assign cur_rem  = '0;
			assign cur_root = '0;
			assign cur_side = in_side;
		end else begin : g_next
			assign cur_v    = v_s[k-1];
			assign cur_rad  = rad_s[k-1];
			assign cur_rem  = rem_s[k-1];
			assign cur_root = root_s[k-1];
			assign cur_side = side_s[k-1];
		end

		// Bring down two radicand bits and try the next root bit
		assign trial = {cur_rem, cur_rad[63:62]};
		assign sub   = {1'b0, cur_root, 2'b01};
		assign ge    = (trial >= sub);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= {cur_rad[61:0], 2'b00};
				rem_s[k]  <= ge ? 33'(trial - sub) : trial[32:0];
				root_s[k] <= {cur_root[30:0], ge};
				side_s[k] <= cur_side;
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign root      = root_s[N-1];
	assign out_side  = side_s[N-1];

endmodule

`default_nettype wire

// ===== src/vnorm_div.sv =====
// ----------------------------------------------------------------------------
// vnorm_div
// Three-lane pipelined restoring divider: (abs << 30) / magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module vnorm_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      in_valid,
	input  wire logic [31:0]               divisor,
	input  wire vnorm_pkg::side_t          in_side,
	output logic                           out_valid,
	output logic [31:0]                    out_divisor,
	output vnorm_pkg::flags_t              out_flags,
	output logic [vnorm_pkg::NUM_COMP-1:0][30:0] quot
);

	localparam int unsigned N = vnorm_pkg::DIV_STAGES;
	localparam int unsigned L = vnorm_pkg::NUM_COMP;

	logic                     v_s     [N];
	logic [31:0]              dvs_s   [N];
	vnorm_pkg::flags_t        flags_s [N];
	logic [L-1:0][31:0]       rem_s   [N];
	logic [L-1:0][30:0]       quot_s  [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic               cur_v;
		logic [31:0]        cur_dvs;
		vnorm_pkg::flags_t  cur_flags;
		logic [L-1:0][31:0] cur_rem;
		logic [L-1:0][30:0] cur_quot;
		logic [L-1:0]       bit_in;
		logic [L-1:0][31:0] nxt_rem;
		logic [L-1:0]       ge;

		if (k == 0) begin : g_first
			assign cur_v     = in_valid;
			assign cur_dvs   = divisor;
			assign cur_flags = in_side.flags;
			assign cur_quot  = '0;
			// Dividend is abs << 30: the top bits seed the remainder,
			// abs bit 0 comes down first, then only zeros
			for (genvar l = 0; l < L; l++) begin : g_seed
				assign cur_rem[l] = {1'b0, in_side.mag_abs[l][31:1]};
				assign bit_in[l]  = in_side.mag_abs[l][0];
			end
		end else begin : g_next
			assign cur_v     = v_s[k-1];
			assign cur_dvs   = dvs_s[k-1];
			assign cur_flags = flags_s[k-1];
			assign cur_rem   = rem_s[k-1];
			assign cur_quot  = quot_s[k-1];
			assign bit_in    = '0;
		end

		// Shift in one dividend bit per lane and subtract where it fits
		for (genvar l = 0; l < L; l++) begin : g_lane
			logic [32:0] trial;
			assign trial      = {cur_rem[l], bit_in[l]};
			assign ge[l]      = (trial >= {1'b0, cur_dvs});
			assign nxt_rem[l] = ge[l] ? 32'(trial - {1'b0, cur_dvs}) : trial[31:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dvs_s[k]   <= cur_dvs;
				flags_s[k] <= cur_flags;
				rem_s[k]   <= nxt_rem;
				for (int l = 0; l < L; l++) begin
					quot_s[k][l] <= {cur_quot[l][29:0], ge[l]};
				end
			end
		end
	end

	assign out_valid   = v_s[N-1];
	assign out_divisor = dvs_s[N-1];
	assign out_flags   = flags_s[N-1];
	assign quot        = quot_s[N-1];

endmodule

`default_nettype wire

// ===== src/vector3_normalize.sv =====
// ----------------------------------------------------------------------------
// vector3_normalize
// Normalizes a signed Q16.16 3D vector to Q1.30 and reports its magnitude.
// ----------------------------------------------------------------------------
// The block takes one vector word per clock while the output side is not
// stalled and returns one result word per vector, in order: the abs, square
// and sum stages, the square root (one root bit per stage), the division
// (one quotient bit per stage, all three components side by side) and one
// output register. The whole pipeline advances together whenever the
// output register is empty or being taken, so s_tready follows that and a
// stall on the output side holds every stage in place.
`default_nettype none

module vector3_normalize (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	// x_in[31:0], y_in[63:32], z_in[95:64]
	input  wire logic [95:0]   s_tdata,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	// x_unit[31:0], y_unit[63:32], z_unit[95:64], magnitude[127:96],
	// div_by_zero[128], zero fill [135:129]
	output logic [135:0]       m_tdata
);

	localparam int unsigned L = vnorm_pkg::NUM_COMP;

	logic en;

	logic                  v_s1, v_s2, v_s3;
	logic [L-1:0][31:0]    abs_s1, abs_s2, abs_s3;
	logic [L-1:0]          neg_s1, neg_s2, neg_s3;
	logic [L-1:0][63:0]    sq_s2;
	logic [63:0]           sum_s3;
	logic                  zero_s3;

	vnorm_pkg::side_t      side_in;
	logic                  sq_valid;
	logic [31:0]           sq_root;
	vnorm_pkg::side_t      sq_side;

	logic                  dv_valid;
	logic [31:0]           dv_mag;
	vnorm_pkg::flags_t     dv_flags;
	logic [L-1:0][30:0]    dv_quot;

	logic                  out_valid_q;
	logic [135:0]          out_data_q;

	// Advance the whole pipeline when the output slot frees up
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: split off signs and take magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < L; l++) begin
				neg_s1[l] <= s_tdata[32*l+31];
				abs_s1[l] <= s_tdata[32*l+31] ? 32'(-s_tdata[32*l +: 32])
				                              : s_tdata[32*l +: 32];
			end
		end
	end

	// Stage 2: square each component
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < L; l++) begin
				sq_s2[l] <= 64'(abs_s1[l]) * 64'(abs_s1[l]);
			end
			abs_s2 <= abs_s1;
			neg_s2 <= neg_s1;
		end
	end

	// Stage 3: add the squares, flag the zero vector
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			zero_s3 <= (abs_s2 == '0);
			abs_s3  <= abs_s2;
			neg_s3  <= neg_s2;
		end
	end

	assign side_in.flags.zero = zero_s3;
	assign side_in.flags.neg  = neg_s3;
	assign side_in.mag_abs    = abs_s3;

	vnorm_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.radicand  (sum_s3),
		.in_side   (side_in),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_side  (sq_side)
	);

	vnorm_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (sq_valid),
		.divisor     (sq_root),
		.in_side     (sq_side),
		.out_valid   (dv_valid),
		.out_divisor (dv_mag),
		.out_flags   (dv_flags),
		.quot        (dv_quot)
	);

	// Output word: restore signs, force zero for the zero vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < L; l++) begin
				if (dv_flags.zero) begin
					out_data_q[32*l +: 32] <= '0;
				end else if (dv_flags.neg[l]) begin
					out_data_q[32*l +: 32] <= 32'(-{1'b0, dv_quot[l]});
				end else begin
					out_data_q[32*l +: 32] <= {1'b0, dv_quot[l]};
				end
			end
			out_data_q[127:96]  <= dv_flags.zero ? 32'd0 : dv_mag;
			out_data_q[128]     <= dv_flags.zero;
			out_data_q[135:129] <= '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

// ===== src/vnorm_checker.sv =====
// ----------------------------------------------------------------------------
// vnorm_checker
// Port-level assertions for vector3_normalize, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vnorm_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [135:0] m_tdata
);

	// Hold a stalled result word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// Take input whenever the output slot is free
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output slot");

	// Zero vector gives zero components and magnitude
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[128] |-> m_tdata[127:0] == 128'd0)
		else $error("zero vector result not cleared");

	// A nonzero vector has a nonzero magnitude
	a_mag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[128] |-> m_tdata[127:96] != 32'd0)
		else $error("nonzero vector with zero magnitude");

	// Unit x component stays within plus or minus one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[31:0]) <= 32'sd1073741824)
		          && ($signed(m_tdata[31:0]) >= -32'sd1073741824))
		else $error("unit component out of range");

endmodule

bind vector3_normalize vnorm_checker u_vnorm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
